// ===== rtl/bf3_pkg.sv =====
// bf3_pkg: shared widths, constants and register codes of the 3x3 box filter
// used by the stream interfaces, the filter sub-blocks and the top level
`default_nettype none

package bf3_pkg;

  localparam int PIXEL_W = 8;
  localparam int COORD_W = 10;
  localparam int SIZE_W  = 11;
  localparam int LEVEL_W = 8;
  localparam int SUM_W   = 12;   // nine 8-bit values
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int COUNT_LIMIT       = 1024;

  localparam logic [SIZE_W-1:0]  MIN_SIZE     = 11'd3;
  localparam logic [SIZE_W-1:0]  SIZE_RESET   = 11'd1024;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET  = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_CAP    = 8'd255;
  localparam logic [COORD_W-1:0] FIRST_INNER  = 10'd2;

  // divide by nine: floor(sum * 3641 / 2^15) is exact for sum below 2^15
  localparam int RECIP_W     = 12;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int QUOT_W      = 9;
  localparam int RECIP_SHIFT = 15;
  localparam logic [RECIP_W-1:0] KERNEL_RECIP = 12'd3641;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_MAX_LEVEL    = 2'd2
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/bf3_if.sv =====
// bf3 stream interfaces: pixel request channel and filtered result channel
// depends on bf3_pkg for field widths
`default_nettype none

interface bf3_pix_if;
  logic                        valid;
  logic                        ready;
  logic [bf3_pkg::PIXEL_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bf3_res_if;
  logic                        valid;
  logic                        ready;
  logic [bf3_pkg::PIXEL_W-1:0] filtered_pixel;
  logic [bf3_pkg::COORD_W-1:0] centre_row;
  logic [bf3_pkg::COORD_W-1:0] centre_col;
  logic                        frame_last;

  modport source (output valid, output filtered_pixel, output centre_row,
                  output centre_col, output frame_last, input ready);
  modport sink   (input valid, input filtered_pixel, input centre_row,
                  input centre_col, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/bf3_line_store.sv =====
// bf3_line_store: the two row buffers (upper and middle) of the 3x3 window
// one registered read and one write per cycle; depends on bf3_pkg
`default_nettype none

module bf3_line_store #(
  parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEFAULT,
  parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [ADDR_W-1:0]           rd_addr,
  input  wire logic                        wr_en,
  input  wire logic [ADDR_W-1:0]           wr_addr,
  input  wire logic [bf3_pkg::PIXEL_W-1:0] wr_upper,
  input  wire logic [bf3_pkg::PIXEL_W-1:0] wr_middle,
  output logic      [bf3_pkg::PIXEL_W-1:0] rd_upper,
  output logic      [bf3_pkg::PIXEL_W-1:0] rd_middle
);

  logic [bf3_pkg::PIXEL_W-1:0] upper_mem  [MAX_WIDTH];
  logic [bf3_pkg::PIXEL_W-1:0] middle_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  // read data holds until the next read so a stalled pixel keeps its column
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bf3_mean.sv =====
// bf3_mean: window sum divided by nine by reciprocal multiply, then limited
// to 255 and to the configured grey level; depends on bf3_pkg
`default_nettype none

module bf3_mean (
  input  wire logic [bf3_pkg::SUM_W-1:0]   sum,
  input  wire logic [bf3_pkg::LEVEL_W-1:0] max_level,
  output logic      [bf3_pkg::PIXEL_W-1:0] mean
);

  logic [bf3_pkg::PROD_W-1:0]  prod;
  logic [bf3_pkg::QUOT_W-1:0]  quot;
  logic [bf3_pkg::PIXEL_W-1:0] capped;

  always_comb begin
    prod = bf3_pkg::PROD_W'(sum) * bf3_pkg::PROD_W'(bf3_pkg::KERNEL_RECIP);
    quot = prod[bf3_pkg::RECIP_SHIFT +: bf3_pkg::QUOT_W];
    if (quot > bf3_pkg::QUOT_W'(bf3_pkg::LEVEL_CAP)) begin
      capped = bf3_pkg::LEVEL_CAP;
    end else begin
      capped = quot[bf3_pkg::PIXEL_W-1:0];
    end
    if (capped > max_level) begin
      mean = max_level;
    end else begin
      mean = capped;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/box_filter_3x3.sv =====
// box_filter_3x3: streaming 3x3 mean filter over a raster-order grey image
// a result leaves res via input, sum and result registers once the pixel
// below-right of its centre is accepted; one pixel per clock while res is
// ready; each row buffer's single read and write port serves once per pixel
// reset: rst (synchronous) clears counters, window, pipeline valids, resets
// the registers; the row buffers are not cleared, rows 0 and 1 refill them
`default_nettype none

module box_filter_3x3 #(
  parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bf3_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bf3_pkg::DATA_W-1:0]   pwdata,
  output logic      [bf3_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  bf3_pix_if.sink                           pix,
  bf3_res_if.source                         res
);

  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int WIDTH_TOP = (MAX_WIDTH < bf3_pkg::COUNT_LIMIT) ? MAX_WIDTH
                                                                 : bf3_pkg::COUNT_LIMIT;
  localparam int SIZE_W    = bf3_pkg::SIZE_W;
  localparam int COORD_W   = bf3_pkg::COORD_W;
  localparam int PIXEL_W   = bf3_pkg::PIXEL_W;
  localparam int SUM_W     = bf3_pkg::SUM_W;

  // configuration registers
  logic [SIZE_W-1:0]           image_width;
  logic [SIZE_W-1:0]           image_height;
  logic [bf3_pkg::LEVEL_W-1:0] max_level;
  bf3_pkg::reg_idx_t           reg_sel;
  logic                        cfg_write;

  // raster position of the next pixel
  logic [COORD_W-1:0] col_count;
  logic [COORD_W-1:0] row_count;

  // input stage
  logic               a_valid;
  logic [PIXEL_W-1:0] a_pixel;
  logic [COORD_W-1:0] a_col;
  logic               a_produce;
  logic [COORD_W-1:0] a_centre_row;
  logic [COORD_W-1:0] a_centre_col;
  logic               a_last;

  // sum stage
  logic               b_valid;
  logic [SUM_W-1:0]   b_sum;
  logic [COORD_W-1:0] b_centre_row;
  logic [COORD_W-1:0] b_centre_col;
  logic               b_last;

  // result register
  logic               out_valid;
  logic [PIXEL_W-1:0] out_pixel;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               out_last;

  logic [PIXEL_W-1:0] window [6];
  logic [PIXEL_W-1:0] rd_upper;
  logic [PIXEL_W-1:0] rd_middle;
  logic [PIXEL_W-1:0] mean;
  logic [SUM_W-1:0]   sum;

  logic [SIZE_W-1:0]  w_used;
  logic [SIZE_W-1:0]  h_used;
  logic               start_wrap;
  logic [SIZE_W-1:0]  row_step;
  logic [COORD_W-1:0] cur_col;
  logic [COORD_W-1:0] cur_row;
  logic [SIZE_W-1:0]  col_step;
  logic               end_wrap;
  logic [SIZE_W-1:0]  row_after;
  logic [COORD_W-1:0] col_count_next;
  logic [COORD_W-1:0] row_count_next;
  logic               cur_produce;
  logic               cur_last;

  logic c_free;
  logic b_free;
  logic a_move;
  logic accept;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = bf3_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (reg_sel)
      bf3_pkg::REG_IMAGE_WIDTH:  prdata = bf3_pkg::DATA_W'(image_width);
      bf3_pkg::REG_IMAGE_HEIGHT: prdata = bf3_pkg::DATA_W'(image_height);
      bf3_pkg::REG_MAX_LEVEL:    prdata = bf3_pkg::DATA_W'(max_level);
      default:                   prdata = '0;
    endcase
  end

  // sizes as used, limited to the supported range
  always_comb begin
    if (image_width < bf3_pkg::MIN_SIZE) begin
      w_used = bf3_pkg::MIN_SIZE;
    end else if (image_width > SIZE_W'(WIDTH_TOP)) begin
      w_used = SIZE_W'(WIDTH_TOP);
    end else begin
      w_used = image_width;
    end
    if (image_height < bf3_pkg::MIN_SIZE) begin
      h_used = bf3_pkg::MIN_SIZE;
    end else if (image_height > SIZE_W'(bf3_pkg::COUNT_LIMIT)) begin
      h_used = SIZE_W'(bf3_pkg::COUNT_LIMIT);
    end else begin
      h_used = image_height;
    end
  end

  // ---------------- position of the arriving pixel ----------------
  always_comb begin
    // counters may lie beyond a size that shrank while idle
    start_wrap = {1'b0, col_count} >= w_used;
    row_step   = start_wrap ? {1'b0, row_count} + 1'b1 : {1'b0, row_count};
    cur_col    = start_wrap ? '0 : col_count;
    cur_row    = (row_step >= h_used) ? '0 : row_step[COORD_W-1:0];

    col_step       = {1'b0, cur_col} + 1'b1;
    end_wrap       = col_step >= w_used;
    row_after      = end_wrap ? {1'b0, cur_row} + 1'b1 : {1'b0, cur_row};
    col_count_next = end_wrap ? '0 : col_step[COORD_W-1:0];
    row_count_next = (row_after >= h_used) ? '0 : row_after[COORD_W-1:0];

    cur_produce = (cur_row >= bf3_pkg::FIRST_INNER) && (cur_col >= bf3_pkg::FIRST_INNER);
    cur_last    = ({1'b0, cur_row} == h_used - 1'b1) && ({1'b0, cur_col} == w_used - 1'b1);
  end

  // ---------------- handshake ----------------
  assign c_free    = !out_valid || res.ready;
  assign b_free    = !b_valid || c_free;
  assign a_move    = a_valid && (!a_produce || b_free);
  assign pix.ready = !a_valid || a_move;
  assign accept    = pix.valid && pix.ready;

  // ---------------- row buffers ----------------
  bf3_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (ADDR_W'(cur_col)),
    .wr_en     (a_move),
    .wr_addr   (ADDR_W'(a_col)),
    .wr_upper  (rd_middle),
    .wr_middle (a_pixel),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  // window columns c-2, c-1 of each row plus the column read this cycle
  assign sum = SUM_W'(window[0]) + SUM_W'(window[1]) + SUM_W'(rd_upper)
             + SUM_W'(window[2]) + SUM_W'(window[3]) + SUM_W'(rd_middle)
             + SUM_W'(window[4]) + SUM_W'(window[5]) + SUM_W'(a_pixel);

  bf3_mean u_mean (
    .sum       (b_sum),
    .max_level (max_level),
    .mean      (mean)
  );

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bf3_pkg::SIZE_RESET;
      image_height <= bf3_pkg::SIZE_RESET;
      max_level    <= bf3_pkg::LEVEL_RESET;
      col_count    <= '0;
      row_count    <= '0;
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        window[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (reg_sel)
          bf3_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[SIZE_W-1:0];
          bf3_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[SIZE_W-1:0];
          bf3_pkg::REG_MAX_LEVEL:    max_level    <= pwdata[bf3_pkg::LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
      if (pix.ready) begin
        a_valid <= pix.valid;
      end
      if (a_move) begin
        window[0] <= window[1];
        window[1] <= rd_upper;
        window[2] <= window[3];
        window[3] <= rd_middle;
        window[4] <= window[5];
        window[5] <= a_pixel;
      end
      if (b_free) begin
        b_valid <= a_valid && a_produce;
      end
      if (c_free) begin
        out_valid <= b_valid;
      end
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      a_pixel      <= pix.pixel_in;
      a_col        <= cur_col;
      a_produce    <= cur_produce;
      a_centre_row <= cur_row - 1'b1;
      a_centre_col <= cur_col - 1'b1;
      a_last       <= cur_last;
    end
    if (b_free) begin
      b_sum        <= sum;
      b_centre_row <= a_centre_row;
      b_centre_col <= a_centre_col;
      b_last       <= a_last;
    end
    if (c_free) begin
      out_pixel <= mean;
      out_row   <= b_centre_row;
      out_col   <= b_centre_col;
      out_last  <= b_last;
    end
  end

  assign res.valid          = out_valid;
  assign res.filtered_pixel = out_pixel;
  assign res.centre_row     = out_row;
  assign res.centre_col     = out_col;
  assign res.frame_last     = out_last;

endmodule

`default_nettype wire
